>>> rtl/core/tile_index_from_position_defines.svh
// Assertion macro shared by the tile picker RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef TILE_INDEX_FROM_POSITION_DEFINES_SVH
`define TILE_INDEX_FROM_POSITION_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define TIFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

>>> rtl/core/tifp_pkg.sv
// Shared types, constants and the divider step for the tile picker.
// No dependencies.
package tifp_pkg;

  localparam int unsigned MAX_COLS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF = 256;
  localparam int unsigned DIV_BITS     = 16;
  localparam int unsigned DIV_STEP     = 4;
  localparam int unsigned DIV_STAGES   = DIV_BITS / DIV_STEP;

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_COLS   = 3'd1;
  localparam logic [2:0] CFG_ROWS   = 3'd2;
  localparam logic [2:0] CFG_TW     = 3'd3;
  localparam logic [2:0] CFG_TH     = 3'd4;
  localparam logic [2:0] CFG_ORG_X  = 3'd5;
  localparam logic [2:0] CFG_ORG_Y  = 3'd6;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_RECT = 2'd1;
  localparam logic [1:0] MODE_ISO  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [11:0] tile_width;
    logic [11:0] tile_height;
  } cfg_t;

  // one dimension of the restoring divider
  typedef struct packed {
    logic [15:0] n;     // dividend bits still to shift in
    logic [15:0] q;     // quotient so far
    logic [11:0] r;     // partial remainder
    logic [7:0]  frac;  // fraction bits of the offset
  } div_t;

  typedef struct packed {
    logic miss;
    div_t x;
    div_t y;
  } div_item_t;

  typedef struct packed {
    logic        miss;
    logic        lower;
    logic        upper;
    logic [15:0] ccol;
    logic [15:0] crow;
    logic [11:0] rxi;
    logic [39:0] ryw;
    logic [39:0] rxh;
    logic [39:0] hw;
  } mul_t;

  typedef struct packed {
    logic        miss;
    logic [17:0] row;
    logic [15:0] col;
  } res_t;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  column;
    logic [15:0] tile_index;
    logic        hit;
  } out_t;

  function automatic div_t div_step(div_t d, logic [11:0] dv);
    logic [12:0] t;
    div_t o;
    o = d;
    t = {d.r, d.n[15]};
    o.n = {d.n[14:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      o.r = 12'(t - {1'b0, dv});
      o.q = {d.q[14:0], 1'b1};
    end else begin
      o.r = t[11:0];
      o.q = {d.q[14:0], 1'b0};
    end
    return o;
  endfunction

endpackage

>>> rtl/core/tifp_div_stage.sv
// One pipeline stage of the two restoring dividers (x by width, y by height).
// Depends on tifp_pkg.
module tifp_div_stage #(
  parameter int unsigned BITS = tifp_pkg::DIV_STEP
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tifp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  tifp_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tifp_pkg::div_item_t out_item
);

  logic                v_r;
  tifp_pkg::div_item_t item_r;
  tifp_pkg::div_item_t item_nxt;

  always_comb begin
    item_nxt = in_item;
    for (int i = 0; i < BITS; i++) begin
      item_nxt.x = tifp_pkg::div_step(item_nxt.x, cfg.tile_width);
      item_nxt.y = tifp_pkg::div_step(item_nxt.y, cfg.tile_height);
    end
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

>>> rtl/core/tifp_iso.sv
// Remainder products, then diamond-edge compares and row/column pick.
// Depends on tifp_pkg and the assertion macro header.
`include "tile_index_from_position_defines.svh"
module tifp_iso (
  input  logic                clk,
  input  logic                rst_n,
  input  tifp_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  tifp_pkg::div_item_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tifp_pkg::res_t      out_res
);

  logic           v1_r, v2_r, rdy1;
  tifp_pkg::mul_t m_r, m_nxt;
  tifp_pkg::res_t res_r, res_nxt;

  // stage 1: products of remainders and cell size
  always_comb begin
    logic [19:0] rx, ry, h;
    logic [31:0] pyw, pxh;
    logic [23:0] phw;
    rx  = {in_item.x.r, in_item.x.frac};
    ry  = {in_item.y.r, in_item.y.frac};
    h   = {cfg.tile_height, 8'd0};
    pyw = ry * cfg.tile_width;
    pxh = rx * cfg.tile_height;
    phw = cfg.tile_height * cfg.tile_width;
    m_nxt.miss  = in_item.miss;
    m_nxt.lower = {ry, 1'b0} < {1'b0, h};
    m_nxt.upper = {ry, 1'b0} > {1'b0, h};
    m_nxt.ccol  = in_item.x.q;
    m_nxt.crow  = in_item.y.q;
    m_nxt.rxi   = in_item.x.r;
    m_nxt.ryw   = {pyw, 8'd0};
    m_nxt.rxh   = {pxh, 8'd0};
    m_nxt.hw    = {phw, 16'd0};
  end

  // stage 2: edge tests, row and column
  always_comb begin
    logic [42:0] a, b, hw, hw3;
    logic [17:0] crow2;
    logic [10:0] half;
    logic        miss, cnz, cin;
    logic [17:0] row;
    miss  = m_r.miss;
    a     = {2'b0, m_r.ryw, 1'b0};
    b     = {2'b0, m_r.rxh, 1'b0};
    hw    = {3'b0, m_r.hw};
    hw3   = hw + {hw[41:0], 1'b0};
    crow2 = {1'b0, m_r.crow, 1'b0};
    half  = cfg.tile_width[11:1];
    cnz   = m_r.ccol != 16'd0;
    cin   = m_r.ccol < {7'd0, cfg.cols};
    row   = crow2;
    res_nxt.col = m_r.ccol;
    if (cfg.mode == tifp_pkg::MODE_RECT) begin
      row = {2'b0, m_r.crow};
    end else begin
      if (m_r.lower) begin
        if (a + b < hw) begin
          if (m_r.crow == 16'd0 || !cnz) miss = 1'b1;
          row = crow2 - 18'd1;
        end else if (a + hw < b) begin
          if (m_r.crow == 16'd0 || !cin) miss = 1'b1;
          row = crow2 - 18'd1;
        end
      end else if (m_r.upper) begin
        if (a > b + hw) begin
          if (!cnz) miss = 1'b1;
          row = crow2 + 18'd1;
        end else if (a + b > hw3) begin
          if (!cin) miss = 1'b1;
          row = crow2 + 18'd1;
        end
      end
      // odd rows sit half a tile to the right
      if (row[0] && m_r.rxi < {1'b0, half}) begin
        if (!cnz) miss = 1'b1;
        res_nxt.col = m_r.ccol - 16'd1;
      end
    end
    res_nxt.miss = miss;
    res_nxt.row  = row;
  end

  assign rdy1      = !v2_r || out_ready;
  assign in_ready  = !v1_r || rdy1;
  assign out_valid = v2_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (rdy1) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) m_r <= m_nxt;
    if (rdy1 && v1_r) res_r <= res_nxt;
  end

  `TIFP_ASSERT(a_stall_backs_up, (v1_r && v2_r && !out_ready) |-> !in_ready, "iso stall lost")

endmodule

>>> rtl/core/tifp_out.sv
// Bounds check, flat index and the output register.
// Depends on tifp_pkg and the assertion macro header.
`include "tile_index_from_position_defines.svh"
module tifp_out (
  input  logic           clk,
  input  logic           rst_n,
  input  tifp_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  tifp_pkg::res_t in_res,
  output logic           out_valid,
  input  logic           out_ready,
  output tifp_pkg::out_t out_data
);

  logic           v_r;
  tifp_pkg::out_t o_r, o_nxt;

  always_comb begin
    logic [24:0] prod;
    logic        hit;
    prod = in_res.row[15:0] * cfg.cols;
    hit  = !in_res.miss && (in_res.col < {7'd0, cfg.cols}) &&
           (in_res.row < {9'd0, cfg.rows});
    o_nxt.hit        = hit;
    o_nxt.tile_index = hit ? 16'(prod[15:0] + in_res.col) : 16'd0;
    o_nxt.column     = hit ? in_res.col[7:0] : 8'd0;
    o_nxt.row        = hit ? in_res.row[7:0] : 8'd0;
  end

  assign in_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign out_data  = o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) o_r <= o_nxt;
  end

  `TIFP_ASSERT(a_miss_zero, (v_r && !o_r.hit) |-> (o_r.tile_index == 16'd0 && o_r.column == 8'd0 && o_r.row == 8'd0), "miss with nonzero fields")

endmodule

>>> rtl/core/tile_index_from_position.sv
// Tile picker: one transaction per cycle while the output is not stalled.
// Stages: offset, four radix-16 divider stages (4 quotient bits each), products, edge compare,
// index/bounds with output register. Throughput set by the fully pipelined divider.
// Each stage stalls only when full and blocked downstream, so bubbles collapse.
// Synchronous active-low reset clears valid bits and all config registers to zero.
`include "tile_index_from_position_defines.svh"
module tile_index_from_position #(
  parameter int unsigned MAX_COLS = tifp_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = tifp_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // query positions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[23:0], pos_y[47:24]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hit[0], tile_index[16:1], column[24:17], row[32:25]
);

  localparam int unsigned NS = tifp_pkg::DIV_STAGES;

  // config registers
  logic [1:0]  mode_r;
  logic [8:0]  cols_r, rows_r;
  logic [11:0] tw_r, th_r;
  logic [23:0] org_x_r, org_y_r;
  tifp_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= tifp_pkg::MODE_NONE;
      cols_r  <= '0;
      rows_r  <= '0;
      tw_r    <= '0;
      th_r    <= '0;
      org_x_r <= '0;
      org_y_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tifp_pkg::CFG_MODE:  mode_r  <= cfg_data[1:0];
        tifp_pkg::CFG_COLS:  cols_r  <= cfg_data[8:0];
        tifp_pkg::CFG_ROWS:  rows_r  <= cfg_data[8:0];
        tifp_pkg::CFG_TW:    tw_r    <= cfg_data[11:0];
        tifp_pkg::CFG_TH:    th_r    <= cfg_data[11:0];
        tifp_pkg::CFG_ORG_X: org_x_r <= cfg_data;
        tifp_pkg::CFG_ORG_Y: org_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // map size clamped to the build limits
  always_comb begin
    cfg.mode        = mode_r;
    cfg.cols        = ({4'd0, cols_r} > 13'(MAX_COLS)) ? 9'(MAX_COLS) : cols_r;
    cfg.rows        = ({4'd0, rows_r} > 13'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows_r;
    cfg.tile_width  = tw_r;
    cfg.tile_height = th_r;
  end

  // stage 0: offsets from origin and early miss
  logic                v0_r, rdy0;
  tifp_pkg::div_item_t item0_r, item0_nxt;

  always_comb begin
    logic [24:0] dx, dy;
    logic        bad;
    dx  = {in_tdata[23], in_tdata[23:0]} - {org_x_r[23], org_x_r};
    dy  = {in_tdata[47], in_tdata[47:24]} - {org_y_r[23], org_y_r};
    bad = !(cfg.mode == tifp_pkg::MODE_RECT || cfg.mode == tifp_pkg::MODE_ISO) ||
          cfg.cols == 9'd0 || cfg.rows == 9'd0 || tw_r == 12'd0 || th_r == 12'd0;
    item0_nxt.miss   = bad || dx[24] || dy[24];
    item0_nxt.x.n    = dx[23:8];
    item0_nxt.x.q    = '0;
    item0_nxt.x.r    = '0;
    item0_nxt.x.frac = dx[7:0];
    item0_nxt.y.n    = dy[23:8];
    item0_nxt.y.q    = '0;
    item0_nxt.y.r    = '0;
    item0_nxt.y.frac = dy[7:0];
  end

  logic                dv   [NS+1];
  logic                drdy [NS+1];
  tifp_pkg::div_item_t ditem[NS+1];

  assign in_tready = !v0_r || drdy[0];
  assign rdy0      = in_tready;
  assign dv[0]     = v0_r;
  assign ditem[0]  = item0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (rdy0) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) item0_r <= item0_nxt;
  end

  // divider pipeline: column/row of the cell and remainders
  for (genvar s = 0; s < NS; s++) begin : g_div
    tifp_div_stage #(.BITS(tifp_pkg::DIV_STEP)) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg),
      .in_valid (dv[s]),
      .in_ready (drdy[s]),
      .in_item  (ditem[s]),
      .out_valid(dv[s+1]),
      .out_ready(drdy[s+1]),
      .out_item (ditem[s+1])
    );
  end

  logic           iv, ordy;
  tifp_pkg::res_t ires;

  tifp_iso u_iso (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (dv[NS]),
    .in_ready (drdy[NS]),
    .in_item  (ditem[NS]),
    .out_valid(iv),
    .out_ready(ordy),
    .out_res  (ires)
  );

  tifp_pkg::out_t odata;

  tifp_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (iv),
    .in_ready (ordy),
    .in_res   (ires),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (odata)
  );

  assign out_tdata = {7'd0, odata};

  `TIFP_ASSERT(a_stall_from_out, !in_tready |-> out_tvalid, "input stalled with empty output")
  `TIFP_ASSERT(a_pad_zero, out_tvalid |-> out_tdata[39:33] == 7'd0, "tdata pad bits set")

endmodule
